FILE: rtl/core/rycs_pkg.sv
// Package for the RGB to YCbCr subsampler: beat types, register map, coefficients.
package rycs_pkg;

  // Frame geometry
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int POS_W   = $clog2(MAX_DIM);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_SUBSAMPLE_MODE = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_FRAME_WIDTH    = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_FRAME_HEIGHT   = 4'h8;

  // Chroma sampling modes; the unused code behaves as 4:4:4
  localparam logic [1:0] MODE_420 = 2'd0;
  localparam logic [1:0] MODE_422 = 2'd1;
  localparam logic [1:0] MODE_444 = 2'd2;

  localparam logic [1:0]       MODE_RESET   = MODE_420;
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(500);

  // Fixed-point arithmetic: signed Q16 coefficients
  localparam int COEF_FRAC_BITS = 16;
  localparam int ACC_W = COEF_FRAC_BITS + 11;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t COEF_Y_R  = acc_t'(19595);
  localparam acc_t COEF_Y_G  = acc_t'(38470);
  localparam acc_t COEF_Y_B  = acc_t'(7471);
  localparam acc_t COEF_CB_R = acc_t'(11056);
  localparam acc_t COEF_CB_G = acc_t'(21712);
  localparam acc_t COEF_HALF = acc_t'(32768);
  localparam acc_t COEF_CR_G = acc_t'(27440);
  localparam acc_t COEF_CR_B = acc_t'(5328);
  localparam acc_t CHROMA_OFFSET = acc_t'(128 * (1 << COEF_FRAC_BITS));

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]       luma;
    logic [7:0]       chroma_blue;
    logic [7:0]       chroma_red;
    logic             chroma_valid;
    logic [POS_W-1:0] pixel_column;
    logic [POS_W-1:0] pixel_row;
    logic             frame_end;
  } result_t;

  // Truncate a Q16 sum to a byte, clamping to 0..255
  function automatic logic [7:0] to_byte(input acc_t acc);
    logic [7:0] res;
    if (acc[ACC_W-1]) begin
      res = 8'd0;
    end else if (|acc[ACC_W-2:COEF_FRAC_BITS+8]) begin
      res = 8'hFF;
    end else begin
      res = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/rgb_to_ycbcr_subsampler.sv
// RGB to YCbCr converter with 4:2:0 / 4:2:2 / 4:4:4 chroma subsampling.
//
// One RGB pixel per beat in raster order in, one result beat out per pixel, with
// a sustained rate of one pixel per clock while result_stall is low: pixels are
// registered on entry, then luma and chroma are computed by constant multiply-adds
// (full-range BT.601 weights, Q16, truncated and clamped) into the result register.
// Column and row are tracked against frame_width and frame_height (0 acts as 1,
// values above 4096 act as 4096); chroma_valid marks sampling points, which take
// chroma from the top-left pixel of each group; a trailing odd column or row gets
// none where subsampled; chroma fields read 0 where chroma_valid is low. frame_end
// flags a frame's last pixel. Write the registers only while the block is idle.
module rgb_to_ycbcr_subsampler (
  input  logic                          clk,
  input  logic                          rst,
  // Pixel channel
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  rycs_pkg::pixel_t              pixel,
  // Result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output rycs_pkg::result_t             result,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rycs_pkg::ADDR_W-1:0]   paddr,
  input  logic [rycs_pkg::DATA_W-1:0]   pwdata,
  output logic [rycs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  // Configuration registers
  logic [1:0]                   subsample_mode;
  logic [rycs_pkg::DIM_W-1:0]   frame_width;
  logic [rycs_pkg::DIM_W-1:0]   frame_height;

  // Position of the next pixel
  logic [rycs_pkg::POS_W-1:0]   column_count;
  logic [rycs_pkg::POS_W-1:0]   row_count;

  // Input stage
  logic                         s1_valid;
  rycs_pkg::pixel_t             s1_pixel;
  logic [rycs_pkg::POS_W-1:0]   s1_column;
  logic [rycs_pkg::POS_W-1:0]   s1_row;
  logic                         s1_chroma;
  logic                         s1_frame_end;

  logic                         out_free;
  logic                         s1_advance;
  logic                         pixel_accept;
  logic                         cfg_write;

  logic [rycs_pkg::DIM_W-1:0]   width_eff;
  logic [rycs_pkg::DIM_W-1:0]   height_eff;
  logic [rycs_pkg::DIM_W-1:0]   column_inc;
  logic [rycs_pkg::DIM_W-1:0]   row_inc;
  logic                         line_last;
  logic                         last_row;
  logic                         column_ok;
  logic                         row_ok;
  logic                         chroma_sample;

  rycs_pkg::acc_t               red_ext;
  rycs_pkg::acc_t               green_ext;
  rycs_pkg::acc_t               blue_ext;
  rycs_pkg::acc_t               luma_sum;
  rycs_pkg::acc_t               cb_sum;
  rycs_pkg::acc_t               cr_sum;
  rycs_pkg::result_t            result_next;

  // Clamp a frame dimension to 1..MAX_DIM
  function automatic logic [rycs_pkg::DIM_W-1:0] clamp_dim(
    input logic [rycs_pkg::DIM_W-1:0] v
  );
    logic [rycs_pkg::DIM_W-1:0] res;
    if (v == '0) begin
      res = rycs_pkg::DIM_W'(1);
    end else if (v > rycs_pkg::DIM_W'(rycs_pkg::MAX_DIM)) begin
      res = rycs_pkg::DIM_W'(rycs_pkg::MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Handshake: the result register frees when empty or taken
  assign out_free     = !result_valid || !result_stall;
  assign s1_advance   = s1_valid && out_free;
  assign pixel_stall  = s1_valid && !out_free;
  assign pixel_accept = pixel_valid && !pixel_stall;

  // Configuration writes and reads
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      subsample_mode <= rycs_pkg::MODE_RESET;
      frame_width    <= rycs_pkg::WIDTH_RESET;
      frame_height   <= rycs_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr)
        rycs_pkg::ADDR_SUBSAMPLE_MODE: subsample_mode <= pwdata[1:0];
        rycs_pkg::ADDR_FRAME_WIDTH:    frame_width    <= pwdata[rycs_pkg::DIM_W-1:0];
        rycs_pkg::ADDR_FRAME_HEIGHT:   frame_height   <= pwdata[rycs_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      rycs_pkg::ADDR_SUBSAMPLE_MODE: prdata = rycs_pkg::DATA_W'(subsample_mode);
      rycs_pkg::ADDR_FRAME_WIDTH:    prdata = rycs_pkg::DATA_W'(frame_width);
      rycs_pkg::ADDR_FRAME_HEIGHT:   prdata = rycs_pkg::DATA_W'(frame_height);
      default:                       prdata = '0;
    endcase
  end

  // Position decode for the pixel being accepted
  always_comb begin
    width_eff  = clamp_dim(frame_width);
    height_eff = clamp_dim(frame_height);
    column_inc = rycs_pkg::DIM_W'(column_count) + rycs_pkg::DIM_W'(1);
    row_inc    = rycs_pkg::DIM_W'(row_count) + rycs_pkg::DIM_W'(1);
    line_last  = column_inc >= width_eff;
    last_row   = row_inc >= height_eff;
    column_ok  = !column_count[0] && (column_inc < width_eff);
    row_ok     = !row_count[0] && (row_inc < height_eff);
    unique case (subsample_mode)
      rycs_pkg::MODE_420: chroma_sample = column_ok && row_ok;
      rycs_pkg::MODE_422: chroma_sample = column_ok;
      default:            chroma_sample = 1'b1;
    endcase
  end

  // Advance the raster counters on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pixel_accept) begin
      if (line_last) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_inc[rycs_pkg::POS_W-1:0];
      end else begin
        column_count <= column_inc[rycs_pkg::POS_W-1:0];
      end
    end
  end

  // Input register: hold the pixel with its position and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_pixel     <= pixel;
      s1_column    <= column_count;
      s1_row       <= row_count;
      s1_chroma    <= chroma_sample;
      s1_frame_end <= line_last && last_row;
    end
  end

  // Color conversion: constant multiply-adds in Q16
  always_comb begin
    red_ext   = rycs_pkg::acc_t'(s1_pixel.red);
    green_ext = rycs_pkg::acc_t'(s1_pixel.green);
    blue_ext  = rycs_pkg::acc_t'(s1_pixel.blue);
    luma_sum  = rycs_pkg::COEF_Y_R * red_ext + rycs_pkg::COEF_Y_G * green_ext
              + rycs_pkg::COEF_Y_B * blue_ext;
    cb_sum    = rycs_pkg::CHROMA_OFFSET - rycs_pkg::COEF_CB_R * red_ext
              - rycs_pkg::COEF_CB_G * green_ext + rycs_pkg::COEF_HALF * blue_ext;
    cr_sum    = rycs_pkg::CHROMA_OFFSET + rycs_pkg::COEF_HALF * red_ext
              - rycs_pkg::COEF_CR_G * green_ext - rycs_pkg::COEF_CR_B * blue_ext;

    result_next.luma         = rycs_pkg::to_byte(luma_sum);
    result_next.chroma_blue  = s1_chroma ? rycs_pkg::to_byte(cb_sum) : 8'd0;
    result_next.chroma_red   = s1_chroma ? rycs_pkg::to_byte(cr_sum) : 8'd0;
    result_next.chroma_valid = s1_chroma;
    result_next.pixel_column = s1_column;
    result_next.pixel_row    = s1_row;
    result_next.frame_end    = s1_frame_end;
  end

  // Result register: load when free, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result <= result_next;
    end
  end

endmodule
